// ----- rtl/lics_pkg.sv -----
// shared constants and types for the laplace inverse-cdf sampler
package lics_pkg;

  // field widths
  localparam int unsigned SAMPLE_BITS    = 32;
  localparam int unsigned FRACTION_BITS  = 16;
  localparam int unsigned OUT_WIDTH      = 39;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned CFG_INDEX_BITS = 1;

  // internal fixed-point formats
  localparam int unsigned LN_FRAC      = 40;
  localparam int unsigned Z_FRAC       = 60;
  localparam int unsigned SERIES_TERMS = 23;
  localparam logic [39:0] LN2_Q40      = 40'hB1_7217_F7D2;

  // normalization: mantissa below the leading one, padded up to 47 fraction bits
  localparam int unsigned LZ_BITS    = 5;
  localparam int unsigned MANT_BITS  = SAMPLE_BITS - 1;
  localparam int unsigned MANT_PAD   = 47 - MANT_BITS;
  localparam int unsigned DIV_R_BITS = 50;

  // restoring divider: quotient bits per pipeline stage
  localparam int unsigned DIV_STEP   = 2;
  localparam int unsigned DIV_STAGES = Z_FRAC / DIV_STEP;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LOCATION_MU = 1'b0,
    CFG_SCALE_B     = 1'b1
  } cfg_index_e;

  // side information that travels with every beat
  typedef struct packed {
    logic               upper;
    logic               sat;
    logic [LZ_BITS-1:0] lz;
  } tag_t;

  // partial products of a 60 x 60 multiply
  typedef struct packed {
    logic [59:0] hh;
    logic [59:0] hl;
    logic [59:0] lh;
    logic [59:0] ll;
  } pp60_t;

  // partial products of a 60 x 63 reciprocal multiply
  typedef struct packed {
    logic [60:0] hh;
    logic [61:0] hl;
    logic [60:0] lh;
    logic [61:0] ll;
  } pprc_t;

  // series state carried along the term pipeline
  typedef struct packed {
    tag_t        tag;
    logic [59:0] w;
    logic [59:0] sum;
  } ser_t;

endpackage

// ----- rtl/laplace_inverse_cdf_sampler.sv -----
// laplace inverse-cdf sampler: uniform fraction in, laplace distributed fixed-point value out
//
// input channel: uniform_sample_i with in_valid_i / in_stall_o; a beat moves when
// valid is high and stall is low. output channel: laplace_value_o and saturated_o
// with out_valid_o / out_stall_i, same rule.
// configuration: cfg_we_i writes cfg_data_i into register cfg_index_i (0 location,
// 1 scale) at the clock edge; write only while no beat is in flight.
// the path from input beat to output beat has 1 input stage, 2 normalize
// stages, 30 divider stages (2 quotient bits each), 2 squaring stages, 5 stages
// for each of the 23 series terms and 3 output stages.
// throughput is one beat per cycle while the output is not stalled; every stage
// is registered and carries its own valid bit, so bubbles pass through at full rate.
// when the output beat is stalled the whole pipeline holds, and in_stall_o is
// raised in the same cycle; nothing is dropped or repeated.
// reset clears all valid bits, sets location to 0 and scale to 1.
// a zero sample gives the most negative value with saturated_o set.
module laplace_inverse_cdf_sampler (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [lics_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  logic [lics_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [lics_pkg::SAMPLE_BITS-1:0]      uniform_sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [lics_pkg::OUT_WIDTH-1:0] laplace_value_o,
  output logic                                  saturated_o
);
  import lics_pkg::*;

  localparam int unsigned ROUND_SHIFT = LN_FRAC - FRACTION_BITS;
  localparam int unsigned L_BITS      = LN_FRAC + LZ_BITS;
  localparam int unsigned MAG_BITS    = L_BITS + CFG_DATA_BITS;
  localparam int unsigned RND_BITS    = MAG_BITS + 1 - ROUND_SHIFT;
  localparam int unsigned MU_EXT      = OUT_WIDTH - CFG_DATA_BITS - FRACTION_BITS;
  localparam logic [MAG_BITS:0] HALF_LSB = (MAG_BITS + 1)'(1) << (ROUND_SHIFT - 1);

  // 60 x 60 multiply, first half: four 30 x 30 partial products
  function automatic pp60_t mul60_pp(logic [59:0] a, logic [59:0] b);
    pp60_t pp;
    pp.hh = 60'(a[59:30]) * 60'(b[59:30]);
    pp.hl = 60'(a[59:30]) * 60'(b[29:0]);
    pp.lh = 60'(a[29:0])  * 60'(b[59:30]);
    pp.ll = 60'(a[29:0])  * 60'(b[29:0]);
    return pp;
  endfunction

  // 60 x 60 multiply, second half: floor of the product over 2^60
  function automatic logic [59:0] mul60_join(pp60_t pp);
    logic [119:0] full;
    full = (120'(pp.hh) << 60) + (120'(pp.hl) << 30) + (120'(pp.lh) << 30) + 120'(pp.ll);
    return full[119:60];
  endfunction

  // configuration registers
  logic signed [CFG_DATA_BITS-1:0] mu_q;
  logic        [CFG_DATA_BITS-1:0] b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q <= '0;
      b_q  <= CFG_DATA_BITS'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_LOCATION_MU: mu_q <= signed'(cfg_data_i);
        CFG_SCALE_B:     b_q  <= cfg_data_i;
      endcase
    end
  end

  // global advance: hold everything while the output beat is stalled
  logic adv;
  logic out_valid_q;
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // input stage: fold the upper half onto the lower half
  logic                   s0_valid_q;
  tag_t                   s0_tag_q;
  logic [SAMPLE_BITS-1:0] s0_m_q;
  tag_t                   s0_tag_d;
  logic [SAMPLE_BITS-1:0] s0_m_d;

  always_comb begin
    s0_tag_d.upper = uniform_sample_i[SAMPLE_BITS-1];
    s0_tag_d.sat   = (uniform_sample_i == '0);
    s0_tag_d.lz    = '0;
    s0_m_d = s0_tag_d.upper ? (~uniform_sample_i + SAMPLE_BITS'(1)) : uniform_sample_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_tag_q <= s0_tag_d;
      s0_m_q   <= s0_m_d;
    end
  end

  // normalize, coarse part: shifts by 16 and 8
  logic                   na_valid_q;
  tag_t                   na_tag_q;
  logic [SAMPLE_BITS-1:0] na_m_q;
  tag_t                   na_tag_d;
  logic [SAMPLE_BITS-1:0] na_m_d;

  always_comb begin
    na_tag_d = s0_tag_q;
    na_m_d   = s0_m_q;
    if (na_m_d[31:16] == '0) begin
      na_m_d         = {na_m_d[15:0], 16'b0};
      na_tag_d.lz[4] = 1'b1;
    end
    if (na_m_d[31:24] == '0) begin
      na_m_d         = {na_m_d[23:0], 8'b0};
      na_tag_d.lz[3] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      na_valid_q <= 1'b0;
    end else if (adv) begin
      na_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      na_tag_q <= na_tag_d;
      na_m_q   <= na_m_d;
    end
  end

  // divider pipeline registers; index 0 is written by the fine normalize stage
  logic                  dv_valid_q [DIV_STAGES+1];
  tag_t                  dv_tag_q   [DIV_STAGES+1];
  logic [DIV_R_BITS-1:0] dv_r_q     [DIV_STAGES+1];
  logic [Z_FRAC-1:0]     dv_z_q     [DIV_STAGES+1];
  logic [MANT_BITS-1:0]  dv_frac_q  [DIV_STAGES+1];

  // normalize, fine part: shifts by 4, 2 and 1, then set up the divider
  tag_t                   nb_tag_d;
  logic [SAMPLE_BITS-1:0] nb_m_d;

  always_comb begin
    nb_tag_d = na_tag_q;
    nb_m_d   = na_m_q;
    if (nb_m_d[31:28] == '0) begin
      nb_m_d         = {nb_m_d[27:0], 4'b0};
      nb_tag_d.lz[2] = 1'b1;
    end
    if (nb_m_d[31:30] == '0) begin
      nb_m_d         = {nb_m_d[29:0], 2'b0};
      nb_tag_d.lz[1] = 1'b1;
    end
    if (!nb_m_d[31]) begin
      nb_m_d         = {nb_m_d[30:0], 1'b0};
      nb_tag_d.lz[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid_q[0] <= 1'b0;
    end else if (adv) begin
      dv_valid_q[0] <= na_valid_q;
    end
  end

  // numerator starts as f - 1, the mantissa below the leading one
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_tag_q[0]  <= nb_tag_d;
      dv_r_q[0]    <= DIV_R_BITS'({nb_m_d[MANT_BITS-1:0], {MANT_PAD{1'b0}}});
      dv_z_q[0]    <= '0;
      dv_frac_q[0] <= nb_m_d[MANT_BITS-1:0];
    end
  end

  // restoring division z = (f-1)/(f+1), a few quotient bits per stage
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    logic [DIV_R_BITS-1:0] den;
    logic [DIV_R_BITS-1:0] r_d;
    logic [Z_FRAC-1:0]     z_d;

    // divisor f + 1 = 2 + (f - 1)
    assign den = DIV_R_BITS'({2'b10, dv_frac_q[g], {MANT_PAD{1'b0}}});

    always_comb begin
      r_d = dv_r_q[g];
      z_d = dv_z_q[g];
      for (int s = 0; s < DIV_STEP; s++) begin
        r_d = {r_d[DIV_R_BITS-2:0], 1'b0};
        z_d = {z_d[Z_FRAC-2:0], 1'b0};
        if (r_d >= den) begin
          r_d    = r_d - den;
          z_d[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[g+1] <= 1'b0;
      end else if (adv) begin
        dv_valid_q[g+1] <= dv_valid_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_tag_q[g+1]  <= dv_tag_q[g];
        dv_r_q[g+1]    <= r_d;
        dv_z_q[g+1]    <= z_d;
        dv_frac_q[g+1] <= dv_frac_q[g];
      end
    end
  end

  // squaring, partial products of z * z
  logic              sq_valid_q;
  tag_t              sq_tag_q;
  logic [Z_FRAC-1:0] sq_z_q;
  pp60_t             sq_pp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
    end else if (adv) begin
      sq_valid_q <= dv_valid_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_tag_q <= dv_tag_q[DIV_STAGES];
      sq_z_q   <= dv_z_q[DIV_STAGES];
      sq_pp_q  <= mul60_pp(dv_z_q[DIV_STAGES], dv_z_q[DIV_STAGES]);
    end
  end

  // series pipeline registers; index 0 holds p = z, sum = z and w = z^2
  logic              sr_valid_q [SERIES_TERMS+1];
  ser_t              sr_s_q     [SERIES_TERMS+1];
  logic [Z_FRAC-1:0] sr_p_q     [SERIES_TERMS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_valid_q[0] <= 1'b0;
    end else if (adv) begin
      sr_valid_q[0] <= sq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sr_s_q[0].tag <= sq_tag_q;
      sr_s_q[0].w   <= mul60_join(sq_pp_q);
      sr_s_q[0].sum <= sq_z_q;
      sr_p_q[0]     <= sq_z_q;
    end
  end

  // one series term per five stages: p *= w, then sum += p / (2n+1)
  for (genvar n = 1; n <= SERIES_TERMS; n++) begin : g_term
    localparam int unsigned DIVISOR = 2 * n + 1;
    localparam logic [62:0] RECIP   = 63'((65'd1 << 64) / DIVISOR);

    logic              a_valid_q, b_valid_q, c_valid_q, d_valid_q;
    ser_t              a_s_q, b_s_q, c_s_q, d_s_q;
    pp60_t             a_pp_q;
    logic [Z_FRAC-1:0] b_p_q, c_p_q, d_p_q;
    pprc_t             c_pp_q;
    logic [Z_FRAC-1:0] d_qe_q;
    logic [123:0]      qe_full;
    logic [Z_FRAC-1:0] rem;
    logic [Z_FRAC-1:0] quo;

    // reciprocal product gives the quotient or one less
    assign qe_full = (124'(c_pp_q.hh) << 62) + (124'(c_pp_q.hl) << 30)
                   + (124'(c_pp_q.lh) << 32) + 124'(c_pp_q.ll);

    // remainder check fixes the quotient
    assign rem = d_p_q - Z_FRAC'(d_qe_q * Z_FRAC'(DIVISOR));
    assign quo = (rem >= Z_FRAC'(DIVISOR)) ? (d_qe_q + Z_FRAC'(1)) : d_qe_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_valid_q     <= 1'b0;
        b_valid_q     <= 1'b0;
        c_valid_q     <= 1'b0;
        d_valid_q     <= 1'b0;
        sr_valid_q[n] <= 1'b0;
      end else if (adv) begin
        a_valid_q     <= sr_valid_q[n-1];
        b_valid_q     <= a_valid_q;
        c_valid_q     <= b_valid_q;
        d_valid_q     <= c_valid_q;
        sr_valid_q[n] <= d_valid_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        // next odd power, partial products
        a_s_q  <= sr_s_q[n-1];
        a_pp_q <= mul60_pp(sr_p_q[n-1], sr_s_q[n-1].w);
        // next odd power, truncated to q60
        b_s_q  <= a_s_q;
        b_p_q  <= mul60_join(a_pp_q);
        // reciprocal multiply, partial products
        c_s_q     <= b_s_q;
        c_p_q     <= b_p_q;
        c_pp_q.hh <= 61'(b_p_q[59:30]) * 61'(RECIP[62:32]);
        c_pp_q.hl <= 62'(b_p_q[59:30]) * 62'(RECIP[31:0]);
        c_pp_q.lh <= 61'(b_p_q[29:0])  * 61'(RECIP[62:32]);
        c_pp_q.ll <= 62'(b_p_q[29:0])  * 62'(RECIP[31:0]);
        // estimated quotient
        d_s_q  <= c_s_q;
        d_p_q  <= c_p_q;
        d_qe_q <= qe_full[123:64];
        // corrected quotient into the running sum
        sr_s_q[n].tag <= d_s_q.tag;
        sr_s_q[n].w   <= d_s_q.w;
        sr_s_q[n].sum <= d_s_q.sum + quo;
        sr_p_q[n]     <= d_p_q;
      end
    end
  end

  // log magnitude: j * ln2 - ln f, floored at zero
  logic              f1_valid_q;
  tag_t              f1_tag_q;
  logic [L_BITS-1:0] f1_l_q;
  logic [L_BITS-1:0] lnf;
  logic [L_BITS-1:0] whole;
  ser_t              last_s;

  assign last_s = sr_s_q[SERIES_TERMS];
  assign lnf    = L_BITS'(last_s.sum[Z_FRAC-1:Z_FRAC-LN_FRAC-1]);
  assign whole  = L_BITS'(last_s.tag.lz) * L_BITS'(LN2_Q40);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (adv) begin
      f1_valid_q <= sr_valid_q[SERIES_TERMS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_tag_q <= last_s.tag;
      f1_l_q   <= (whole > lnf) ? (whole - lnf) : '0;
    end
  end

  // scale by b
  logic                f2_valid_q;
  tag_t                f2_tag_q;
  logic [MAG_BITS-1:0] f2_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_valid_q <= 1'b0;
    end else if (adv) begin
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f2_tag_q <= f1_tag_q;
      f2_mag_q <= MAG_BITS'(b_q) * MAG_BITS'(f1_l_q);
    end
  end

  // round half up on the signed term, add the location
  logic [MAG_BITS:0]      mag_up;
  logic [MAG_BITS:0]      mag_lo;
  logic [RND_BITS-1:0]    rnd_up;
  logic [RND_BITS-1:0]    rnd_lo;
  logic [OUT_WIDTH-1:0]   term;
  logic [OUT_WIDTH-1:0]   mu_fix;
  logic [OUT_WIDTH-1:0]   value_d;
  logic signed [OUT_WIDTH-1:0] out_value_q;
  logic                   out_sat_q;

  assign mag_up = (MAG_BITS + 1)'(f2_mag_q) + HALF_LSB;
  assign mag_lo = (MAG_BITS + 1)'(f2_mag_q) + HALF_LSB - (MAG_BITS + 1)'(1);
  assign rnd_up = mag_up[MAG_BITS:ROUND_SHIFT];
  assign rnd_lo = mag_lo[MAG_BITS:ROUND_SHIFT];
  assign term   = f2_tag_q.upper ? OUT_WIDTH'(rnd_up) : -OUT_WIDTH'(rnd_lo);
  assign mu_fix = {{MU_EXT{mu_q[CFG_DATA_BITS-1]}}, mu_q, {FRACTION_BITS{1'b0}}};

  // zero sample clamps to the most negative value
  assign value_d = f2_tag_q.sat ? {1'b1, {(OUT_WIDTH-1){1'b0}}} : (mu_fix + term);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= f2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_value_q <= signed'(value_d);
      out_sat_q   <= f2_tag_q.sat;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign laplace_value_o = out_value_q;
  assign saturated_o     = out_sat_q;

endmodule

// ----- verif/tb_laplace_inverse_cdf_sampler.sv -----
// testbench for the laplace inverse-cdf sampler: random and directed samples, self-checking
`timescale 1ns / 1ps

module tb_laplace_inverse_cdf_sampler;
  import lics_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned TAIL_CYCLES  = 160;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned NUM_PHASES   = 6;

  // one expected output beat, tagged with the sample that caused it
  typedef struct {
    logic [SAMPLE_BITS-1:0]      u;
    logic signed [OUT_WIDTH-1:0] value;
    logic                        flag;
  } laplace_beat_t;

  // predicts laplace values from the current location/scale and holds them in order
  class laplace_ledger;
    logic signed [CFG_DATA_BITS-1:0] location;
    logic [CFG_DATA_BITS-1:0]        scale;
    laplace_beat_t                   waiting_q[$];
    int unsigned                     mismatches;
    int unsigned                     checked;
    int unsigned                     saturations;

    function new();
      location    = '0;
      scale       = 16'd1;
      mismatches  = 0;
      checked     = 0;
      saturations = 0;
    endfunction

    function void set_register(cfg_index_e idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_LOCATION_MU: location = data;
        CFG_SCALE_B:     scale = data;
        default:         ;
      endcase
    endfunction

    // floor(a * b / 2^60)
    function logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[123:60];
    endfunction

    // |ln(m / 2^31)| in q40 fixed point
    function logic [63:0] abs_log_q40(logic [63:0] m);
      int          k;
      int          i;
      int          n;
      logic [63:0] fnum, num, den, quo, rem, z2, acc, pw, ln_f, whole;
      k = 47;
      while (k > 0 && m[k] == 1'b0) k--;
      fnum = m << (47 - k);
      num  = fnum - (64'd1 << 47);
      den  = fnum + (64'd1 << 47);
      // z = (f-1)/(f+1), bitwise long division
      quo  = '0;
      rem  = num;
      for (i = 0; i < Z_FRAC; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= den) begin
          rem    = rem - den;
          quo[0] = 1'b1;
        end
      end
      // odd power series in z
      z2  = frac_mul(quo, quo);
      acc = quo;
      pw  = quo;
      for (n = 1; n <= SERIES_TERMS; n++) begin
        pw  = frac_mul(pw, z2);
        acc = acc + pw / 64'(2 * n + 1);
      end
      ln_f  = (acc << 1) >> (Z_FRAC - LN_FRAC);
      whole = 64'(SAMPLE_BITS - 1 - k) * 64'(LN2_Q40);
      return (whole > ln_f) ? whole - ln_f : 64'd0;
    endfunction

    function laplace_beat_t predict(logic [SAMPLE_BITS-1:0] u);
      laplace_beat_t beat;
      logic [63:0]   m;
      logic [63:0]   mag;
      longint        term;
      longint        base;
      longint        y;
      longint        top;
      int            sh;
      beat.u     = u;
      beat.flag  = 1'b0;
      beat.value = '0;
      sh         = LN_FRAC - FRACTION_BITS;
      top        = (longint'(1) << (OUT_WIDTH - 1)) - 1;
      // log of zero: clamp low and flag it
      if (u == '0) begin
        beat.value = {1'b1, {(OUT_WIDTH - 1){1'b0}}};
        beat.flag  = 1'b1;
        return beat;
      end
      m   = u[SAMPLE_BITS-1] ? (64'd1 << SAMPLE_BITS) - 64'(u) : 64'(u);
      mag = 64'(scale) * abs_log_q40(m);
      // round half up on the signed term
      if (u[SAMPLE_BITS-1]) begin
        term = longint'((mag + (64'd1 << (sh - 1))) >> sh);
      end else begin
        term = -longint'((mag + (64'd1 << (sh - 1)) - 64'd1) >> sh);
      end
      base = longint'(location);
      y    = base * (longint'(1) << FRACTION_BITS) + term;
      if (y > top) y = top;
      if (y < -top - 1) y = -top - 1;
      beat.value = y[OUT_WIDTH-1:0];
      return beat;
    endfunction

    function void note_sample(logic [SAMPLE_BITS-1:0] u);
      waiting_q.push_back(predict(u));
    endfunction

    function void check_value(logic signed [OUT_WIDTH-1:0] value, logic flag);
      laplace_beat_t want;
      checked++;
      if (flag === 1'b1) saturations++;
      if (waiting_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected output beat value=%0d saturated=%b", value, flag);
        return;
      end
      want = waiting_q.pop_front();
      if (value !== want.value || flag !== want.flag) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: sample 0x%08h: expected value=%0d saturated=%b, got value=%0d saturated=%b",
                   want.u, want.value, want.flag, value, flag);
      end
    endfunction

    function int unsigned outstanding();
      return waiting_q.size();
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [CFG_INDEX_BITS-1:0]    cfg_index_i;
  logic [CFG_DATA_BITS-1:0]     cfg_data_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [SAMPLE_BITS-1:0]       uniform_sample_i;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic signed [OUT_WIDTH-1:0]  laplace_value_o;
  logic                         saturated_o;

  laplace_ledger ledger = new();

  int unsigned cycle_count    = 0;
  int unsigned stall_cycles   = 0;
  int unsigned settings_used  = 0;
  int unsigned sink_hold      = 0;
  bit          src_gaps_on    = 1'b1;
  bit          sink_stalls_on = 1'b1;

  laplace_inverse_cdf_sampler DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .uniform_sample_i (uniform_sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .laplace_value_o  (laplace_value_o),
    .saturated_o      (saturated_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // output side: check accepted beats, stall in random bursts
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      ledger.check_value(laplace_value_o, saturated_o);
    if (out_stall_i) stall_cycles++;
    if (sink_hold > 0) begin
      sink_hold--;
      out_stall_i <= 1'b1;
    end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
      sink_hold = $urandom_range(0, 6);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog
  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("CHECK FAILED");
    $finish;
  end

  // present one sample and hold it until the block takes the beat
  task automatic feed_sample(input logic [SAMPLE_BITS-1:0] u);
    in_valid_i       <= 1'b1;
    uniform_sample_i <= u;
    do @(posedge clk_i); while (in_stall_o);
    ledger.note_sample(u);
    // occasional gap on the input side
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // stop sending and wait until every predicted beat has come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk_i);
  endtask

  // write location then scale; only called with the pipeline empty
  task automatic program_shape(input logic signed [CFG_DATA_BITS-1:0] mu,
                               input logic [CFG_DATA_BITS-1:0] sc);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_LOCATION_MU;
    cfg_data_i  <= mu;
    @(posedge clk_i);
    ledger.set_register(CFG_LOCATION_MU, mu);
    cfg_index_i <= CFG_SCALE_B;
    cfg_data_i  <= sc;
    @(posedge clk_i);
    ledger.set_register(CFG_SCALE_B, sc);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // samples weighted toward the tails, the midpoint and powers of two
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    logic [SAMPLE_BITS-1:0] u;
    case ($urandom_range(0, 7))
      0, 1, 2: u = $urandom;
      3:       u = $urandom >> $urandom_range(1, 31);
      4:       u = 32'hFFFF_FFFF - ($urandom >> $urandom_range(1, 31));
      5:       u = 32'h8000_0000 + $urandom_range(0, 64) - 32;
      6: begin
        u = 32'd1 << $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) u = -u;
      end
      default: begin
        case ($urandom_range(0, 2))
          0:       u = '0;
          1:       u = 32'd1;
          default: u = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return u;
  endfunction

  initial begin
    int unsigned                     p;
    int unsigned                     i;
    logic signed [CFG_DATA_BITS-1:0] mu;
    logic [CFG_DATA_BITS-1:0]        sc;

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = CFG_LOCATION_MU;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    uniform_sample_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: zero, smallest, midpoint and its neighbours, largest, and the quarter points
    feed_sample(32'h0000_0000);
    feed_sample(32'h0000_0001);
    feed_sample(32'h8000_0000);
    feed_sample(32'h7FFF_FFFF);
    feed_sample(32'h8000_0001);
    feed_sample(32'hFFFF_FFFF);
    feed_sample(32'h4000_0000);
    feed_sample(32'hC000_0000);

    // most negative location, largest scale
    wait_for_results();
    program_shape(-16'sd32768, 16'hFFFF);
    feed_sample(32'h0000_0000);
    feed_sample(32'h0000_0001);
    feed_sample(32'hFFFF_FFFF);
    feed_sample(32'h8000_0000);
    feed_sample(32'h7FFF_FFFF);

    // most positive location, largest scale
    wait_for_results();
    program_shape(16'sd32767, 16'hFFFF);
    feed_sample(32'h0000_0001);
    feed_sample(32'hFFFF_FFFF);
    feed_sample(32'h0000_FFFF);

    // zero scale: the log term vanishes
    wait_for_results();
    program_shape(16'sd12345, 16'h0000);
    feed_sample(32'hDEAD_BEEF);
    feed_sample(32'h1234_5678);
    feed_sample(32'h0000_0000);
    feed_sample(32'h8000_0000);

    // random phases, each with its own shape and idling mix
    for (p = 0; p < NUM_PHASES; p++) begin
      wait_for_results();
      case (p)
        0: begin
          mu = CFG_DATA_BITS'($urandom);
          sc = CFG_DATA_BITS'($urandom);
        end
        1: begin
          mu = '0;
          sc = 16'd1;
        end
        2: begin
          mu = CFG_DATA_BITS'($urandom);
          sc = CFG_DATA_BITS'($urandom_range(1, 16));
        end
        3: begin
          mu = -16'sd32768;
          sc = 16'hFFFF;
        end
        4: begin
          mu = 16'sd32767;
          sc = CFG_DATA_BITS'($urandom_range(0, 3));
        end
        default: begin
          mu = CFG_DATA_BITS'($urandom);
          sc = CFG_DATA_BITS'($urandom);
        end
      endcase
      program_shape(mu, sc);
      src_gaps_on    = (p == 0 || p == 2 || p == 3);
      sink_stalls_on = (p == 0 || p == 3 || p == 4);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        feed_sample(pick_sample());
        // halfway through phase 3, hold off the input until the pipeline has fully emptied
        if (p == 3 && i == PHASE_ITEMS / 2) wait_for_results();
      end
    end

    // drain and watch for stray beats
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("summary: %0d output beats checked over %0d location/scale settings, %0d saturated",
             ledger.checked, settings_used + 1, ledger.saturations);
    $display("summary: %0d stalled output cycles, %0d mismatches in %0d cycles",
             stall_cycles, ledger.mismatches, cycle_count);
    if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/lics_pkg.sv
rtl/laplace_inverse_cdf_sampler.sv
verif/tb_laplace_inverse_cdf_sampler.sv
